// File: design/sorted_timer_event_queue_core_assert.svh
// Assertion macros for the sorted timer event queue core.
// Used by the sequencer; needs only the clock and active-low reset names passed in.
`ifndef SORTED_TIMER_EVENT_QUEUE_CORE_ASSERT_SVH
`define SORTED_TIMER_EVENT_QUEUE_CORE_ASSERT_SVH

// Property that must hold at every edge outside reset.
`define STQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define STQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/stq_pkg.sv
// Shared types and codes for the sorted timer event queue.
// No dependencies.
`default_nettype none

package stq_pkg;

  localparam int TIME_W = 32;
  localparam int OP_W   = 3;
  localparam int KIND_W = 4;

  typedef logic [TIME_W-1:0] tick_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam op_t OP_ADD     = 3'd0;
  localparam op_t OP_CANCEL  = 3'd1;
  localparam op_t OP_QUERY   = 3'd2;
  localparam op_t OP_ADVANCE = 3'd3;
  localparam op_t OP_CLEAR   = 3'd4;

  localparam kind_t KIND_ADDED      = 4'd0;
  localparam kind_t KIND_FULL       = 4'd1;
  localparam kind_t KIND_CANCELLED  = 4'd2;
  localparam kind_t KIND_FOUND      = 4'd3;
  localparam kind_t KIND_NOT_FOUND  = 4'd4;
  localparam kind_t KIND_FIRED      = 4'd5;
  localparam kind_t KIND_FIRED_NONE = 4'd6;
  localparam kind_t KIND_ADV_DONE   = 4'd7;
  localparam kind_t KIND_CLEARED    = 4'd8;

  // Flags from the entry compare unit
  typedef struct packed {
    logic dl_after;    // entry deadline above the deadline being added
    logic due;         // entry deadline at or below the advance target
    logic cancel_hit;  // entry matches the cancel rules
    logic query_hit;   // entry handler and payload both match
  } cmp_res_t;

endpackage

`default_nettype wire

// File: design/stq_in_if.sv
// Input channel of the timer queue: one operation per beat.
// Depends on stq_pkg.
`default_nettype none

interface stq_in_if #(
  parameter int HANDLER_BITS = 8,
  parameter int PAYLOAD_BITS = 16
) ();
  logic                    valid;
  logic                    ready;
  stq_pkg::op_t            operation;
  stq_pkg::tick_t          delay;
  stq_pkg::tick_t          new_time;
  logic [HANDLER_BITS-1:0] handler_id;
  logic [PAYLOAD_BITS-1:0] payload_id;

  modport source (
    output valid, operation, delay, new_time, handler_id, payload_id,
    input  ready
  );
  modport sink (
    input  valid, operation, delay, new_time, handler_id, payload_id,
    output ready
  );
endinterface

`default_nettype wire

// File: design/stq_out_if.sv
// Result channel of the timer queue: one result item per beat.
// Depends on stq_pkg.
`default_nettype none

interface stq_out_if #(
  parameter int HANDLER_BITS = 8,
  parameter int PAYLOAD_BITS = 16,
  parameter int COUNT_BITS   = 5
) ();
  logic                    valid;
  logic                    ready;
  stq_pkg::kind_t          kind;
  logic [HANDLER_BITS-1:0] fired_handler;
  logic [PAYLOAD_BITS-1:0] fired_payload;
  stq_pkg::tick_t          fire_time;
  stq_pkg::tick_t          remaining;
  logic [COUNT_BITS-1:0]   removed_count;
  logic [COUNT_BITS-1:0]   pending_count;
  stq_pkg::tick_t          served_count;
  logic                    last;

  modport source (
    output valid, kind, fired_handler, fired_payload, fire_time, remaining,
           removed_count, pending_count, served_count, last,
    input  ready
  );
  modport sink (
    input  valid, kind, fired_handler, fired_payload, fire_time, remaining,
           removed_count, pending_count, served_count, last,
    output ready
  );
endinterface

`default_nettype wire

// File: design/stq_mem.sv
// Entry store: one write port and one registered read port.
// Generic width and depth; no package dependency.
`default_nettype none

module stq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 56
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: design/stq_cmp.sv
// Shared compare unit: checks one stored entry against the current request.
// Depends on stq_pkg.
`default_nettype none

module stq_cmp #(
  parameter int HANDLER_BITS = 8,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire stq_pkg::tick_t           entry_deadline,
  input  wire logic [HANDLER_BITS-1:0]  entry_handler,
  input  wire logic [PAYLOAD_BITS-1:0]  entry_payload,
  input  wire stq_pkg::tick_t           add_deadline,
  input  wire stq_pkg::tick_t           target_time,
  input  wire logic [HANDLER_BITS-1:0]  req_handler,
  input  wire logic [PAYLOAD_BITS-1:0]  req_payload,
  output stq_pkg::cmp_res_t             res
);
  import stq_pkg::*;

  logic h_null;
  logic p_null;
  logic p_eq;
  logic h_eq;

  assign h_null = (req_handler == '0);
  assign p_null = (req_payload == '0);
  assign p_eq   = (entry_payload == req_payload);
  assign h_eq   = (entry_handler == req_handler);

  always_comb begin
    res.dl_after   = (entry_deadline > add_deadline);
    res.due        = (entry_deadline <= target_time);
    // null handler matches on data; a full request matches data alone;
    // null data also takes entries with the same handler
    res.cancel_hit = (h_null && p_eq) || (!h_null && !p_null && p_eq) || (p_null && h_eq);
    res.query_hit  = h_eq && p_eq;
  end

endmodule

`default_nettype wire

// File: design/stq_seq.sv
// Timer queue sequencer: walks the circular entry store one entry a cycle in
// add/cancel/query via the shared compare unit. Uses stq_pkg, stq_mem, stq_cmp.
`default_nettype none
`include "sorted_timer_event_queue_core_assert.svh"

module stq_seq #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int HANDLER_BITS = 8,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  stq_in_if.sink                                    in_ch,
  output logic                                      res_valid,
  input  wire logic                                 res_ready,
  output stq_pkg::kind_t                            res_kind,
  output logic [HANDLER_BITS-1:0]                   res_handler,
  output logic [PAYLOAD_BITS-1:0]                   res_payload,
  output stq_pkg::tick_t                            res_fire_time,
  output stq_pkg::tick_t                            res_remaining,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]          res_removed,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]          res_pending,
  output stq_pkg::tick_t                            res_served,
  output logic                                      res_last
);
  import stq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int EW = TIME_W + HANDLER_BITS + PAYLOAD_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_X = (CW+1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_CAN  = 3'd2;
  localparam logic [2:0] S_QRY  = 3'd3;
  localparam logic [2:0] S_ADV  = 3'd4;
  localparam logic [2:0] S_ADV2 = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]              state_r,   state_nxt;
  logic [CW-1:0]           count_r,   count_nxt;
  logic [AW-1:0]           head_r,    head_nxt;
  tick_t                   now_r,     now_nxt;
  tick_t                   served_r,  served_nxt;
  logic [CW-1:0]           idx_r,     idx_nxt;
  logic [CW-1:0]           rd_r,      rd_nxt;
  logic                    pend_r,    pend_nxt;
  tick_t                   dl_r,      dl_nxt;
  tick_t                   ntime_r,   ntime_nxt;
  logic [HANDLER_BITS-1:0] h_r,       h_nxt;
  logic [PAYLOAD_BITS-1:0] p_r,       p_nxt;
  kind_t                   kind_r,    kind_nxt;
  tick_t                   rem_r,     rem_nxt;
  logic [CW-1:0]           removed_r, removed_nxt;
  tick_t                   ft_r,      ft_nxt;

  logic                    mem_we;
  logic                    mem_re;
  logic [EW-1:0]           mem_wdata;
  logic [EW-1:0]           mem_rdata;
  logic [AW-1:0]           wr_phys;
  logic [AW-1:0]           rd_phys;
  logic [CW-1:0]           wr_log;
  logic [CW-1:0]           rd_log;
  logic                    new_sel;
  tick_t                   rd_dl;
  logic [HANDLER_BITS-1:0] rd_h;
  logic [PAYLOAD_BITS-1:0] rd_p;
  cmp_res_t                cmp;
  logic [TIME_W:0]         dl_sum;
  logic                    pop;

  // Logical position to slot in the circular store
  function automatic logic [AW-1:0] phys(input logic [CW-1:0] lg);
    logic [CW:0] s;
    s = (CW+1)'(head_r) + (CW+1)'(lg);
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[AW-1:0];
  endfunction

  assign rd_dl = mem_rdata[EW-1 -: TIME_W];
  assign rd_h  = mem_rdata[PAYLOAD_BITS +: HANDLER_BITS];
  assign rd_p  = mem_rdata[PAYLOAD_BITS-1:0];

  assign mem_wdata = new_sel ? {dl_r, h_r, p_r} : mem_rdata;
  assign dl_sum    = {1'b0, now_r} + {1'b0, in_ch.delay};
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    wr_log = idx_r;
    rd_log = rd_r;
    if (state_r == S_ADD) begin
      rd_log = pend_r ? idx_r - CW'(2) : idx_r - CW'(1);
    end else if (state_r == S_ADV) begin
      rd_log = '0;
    end
  end

  assign wr_phys = phys(wr_log);
  assign rd_phys = phys(rd_log);

  stq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_phys),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_phys),
    .rdata (mem_rdata)
  );

  stq_cmp #(
    .HANDLER_BITS (HANDLER_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_cmp (
    .entry_deadline (rd_dl),
    .entry_handler  (rd_h),
    .entry_payload  (rd_p),
    .add_deadline   (dl_r),
    .target_time    (ntime_r),
    .req_handler    (h_r),
    .req_payload    (p_r),
    .res            (cmp)
  );

  assign pop = (state_r == S_ADV2) && cmp.due && res_ready;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    head_nxt    = head_r;
    now_nxt     = now_r;
    served_nxt  = served_r;
    idx_nxt     = idx_r;
    rd_nxt      = rd_r;
    pend_nxt    = pend_r;
    dl_nxt      = dl_r;
    ntime_nxt   = ntime_r;
    h_nxt       = h_r;
    p_nxt       = p_r;
    kind_nxt    = kind_r;
    rem_nxt     = rem_r;
    removed_nxt = removed_r;
    ft_nxt      = ft_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    new_sel     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          dl_nxt      = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
          ntime_nxt   = in_ch.new_time;
          h_nxt       = in_ch.handler_id;
          p_nxt       = in_ch.payload_id;
          idx_nxt     = '0;
          rd_nxt      = '0;
          pend_nxt    = 1'b0;
          rem_nxt     = '0;
          removed_nxt = '0;
          ft_nxt      = '0;
          unique case (in_ch.operation)
            OP_ADD: begin
              if (count_r == DEPTH_C) begin
                kind_nxt  = KIND_FULL;
                state_nxt = S_EMIT;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_ADD;
              end
            end
            OP_CANCEL:  state_nxt = S_CAN;
            OP_QUERY:   state_nxt = S_QRY;
            OP_ADVANCE: state_nxt = S_ADV;
            OP_CLEAR: begin
              count_nxt = '0;
              kind_nxt  = KIND_CLEARED;
              state_nxt = S_EMIT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_ADD: begin
        // walk down from the tail, shifting later deadlines up one slot
        if (pend_r && cmp.dl_after) begin
          mem_we  = 1'b1;
          idx_nxt = idx_r - CW'(1);
          if (idx_r >= CW'(2)) begin
            mem_re   = 1'b1;
            pend_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b0;
          end
        end else if (pend_r || idx_r == '0) begin
          mem_we    = 1'b1;
          new_sel   = 1'b1;
          count_nxt = count_r + CW'(1);
          kind_nxt  = KIND_ADDED;
          state_nxt = S_EMIT;
        end else begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
        end
      end

      S_CAN: begin
        if (!pend_r && rd_r >= count_r) begin
          count_nxt = idx_r;
          kind_nxt  = KIND_CANCELLED;
          state_nxt = S_EMIT;
        end else begin
          if (rd_r < count_r) begin
            mem_re   = 1'b1;
            rd_nxt   = rd_r + CW'(1);
            pend_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b0;
          end
          // compact kept entries toward the head
          if (pend_r) begin
            if (cmp.cancel_hit) begin
              removed_nxt = removed_r + CW'(1);
            end else begin
              mem_we  = 1'b1;
              idx_nxt = idx_r + CW'(1);
            end
          end
        end
      end

      S_QRY: begin
        if (pend_r && cmp.query_hit) begin
          rem_nxt   = rd_dl - now_r;
          kind_nxt  = KIND_FOUND;
          state_nxt = S_EMIT;
        end else if (!pend_r && rd_r >= count_r) begin
          kind_nxt  = KIND_NOT_FOUND;
          state_nxt = S_EMIT;
        end else if (rd_r < count_r) begin
          mem_re   = 1'b1;
          rd_nxt   = rd_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end

      S_ADV: begin
        if (count_r == '0) begin
          now_nxt   = ntime_r;
          ft_nxt    = ntime_r;
          kind_nxt  = KIND_ADV_DONE;
          state_nxt = S_EMIT;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_ADV2;
        end
      end

      S_ADV2: begin
        if (cmp.due) begin
          // hold the head entry until the result slot frees
          if (res_ready) begin
            head_nxt   = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);
            count_nxt  = count_r - CW'(1);
            served_nxt = served_r + TIME_W'(1);
            now_nxt    = rd_dl;
            state_nxt  = S_ADV;
          end
        end else begin
          now_nxt   = ntime_r;
          ft_nxt    = ntime_r;
          kind_nxt  = KIND_ADV_DONE;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res_valid     = (state_r == S_EMIT) || (state_r == S_ADV2 && cmp.due);
    res_kind      = kind_r;
    res_handler   = '0;
    res_payload   = '0;
    res_fire_time = ft_r;
    res_remaining = rem_r;
    res_removed   = removed_r;
    res_pending   = count_r;
    res_served    = served_r;
    res_last      = 1'b1;
    if (state_r == S_ADV2) begin
      res_kind      = (rd_h != '0) ? KIND_FIRED : KIND_FIRED_NONE;
      res_handler   = rd_h;
      res_payload   = rd_p;
      res_fire_time = rd_dl;
      res_remaining = '0;
      res_removed   = '0;
      res_pending   = count_r - CW'(1);
      res_served    = served_r + TIME_W'(1);
      res_last      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      head_r   <= '0;
      now_r    <= '0;
      served_r <= '0;
      idx_r    <= '0;
      rd_r     <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      head_r   <= head_nxt;
      now_r    <= now_nxt;
      served_r <= served_nxt;
      idx_r    <= idx_nxt;
      rd_r     <= rd_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r      <= dl_nxt;
    ntime_r   <= ntime_nxt;
    h_r       <= h_nxt;
    p_r       <= p_nxt;
    kind_r    <= kind_nxt;
    rem_r     <= rem_nxt;
    removed_r <= removed_nxt;
    ft_r      <= ft_nxt;
  end

  `STQ_ASSERT(a_count_bound, clk, rst_n, count_r <= DEPTH_C, "entry count above depth")
  `STQ_ASSERT(a_no_write_idle, clk, rst_n, (state_r == S_IDLE || state_r == S_EMIT) |-> !mem_we, "store written outside a walk")
  `STQ_ASSERT_NEXT(a_pop_count, clk, rst_n, pop, count_r == $past(count_r) - CW'(1), "fired beat did not drop the head")
  `STQ_ASSERT_NEXT(a_served_hold, clk, rst_n, !pop, $stable(served_r), "served total moved without a fired beat")

endmodule

`default_nettype wire

// File: design/sorted_timer_event_queue_core.sv
// Sorted timer event queue. Add walks from the tail down to the insert slot,
// cancel walks every held entry, query walks until the first match; advance
// gives one fired beat per due entry, then a done beat; clear and a refused
// add go straight to their result. One item at a time: the next input beat is
// taken in the cycle after the last result enters the output slot; a stalled output holds it.
// Synchronous active-low reset empties the queue and zeroes time and served count.
`default_nettype none

module sorted_timer_event_queue_core #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int HANDLER_BITS = 8,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  stq_in_if.sink     in_ch,
  stq_out_if.source  out_ch
);
  import stq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic                    res_valid;
  logic                    res_ready;
  kind_t                   res_kind;
  logic [HANDLER_BITS-1:0] res_handler;
  logic [PAYLOAD_BITS-1:0] res_payload;
  tick_t                   res_fire_time;
  tick_t                   res_remaining;
  logic [CW-1:0]           res_removed;
  logic [CW-1:0]           res_pending;
  tick_t                   res_served;
  logic                    res_last;

  logic                    out_valid_r, out_valid_nxt;
  kind_t                   out_kind_r;
  logic [HANDLER_BITS-1:0] out_handler_r;
  logic [PAYLOAD_BITS-1:0] out_payload_r;
  tick_t                   out_fire_time_r;
  tick_t                   out_remaining_r;
  logic [CW-1:0]           out_removed_r;
  logic [CW-1:0]           out_pending_r;
  tick_t                   out_served_r;
  logic                    out_last_r;

  stq_seq #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .HANDLER_BITS (HANDLER_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_kind      (res_kind),
    .res_handler   (res_handler),
    .res_payload   (res_payload),
    .res_fire_time (res_fire_time),
    .res_remaining (res_remaining),
    .res_removed   (res_removed),
    .res_pending   (res_pending),
    .res_served    (res_served),
    .res_last      (res_last)
  );

  // output slot takes a new beat when empty or draining this cycle
  assign res_ready     = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = res_ready ? res_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_kind_r      <= res_kind;
      out_handler_r   <= res_handler;
      out_payload_r   <= res_payload;
      out_fire_time_r <= res_fire_time;
      out_remaining_r <= res_remaining;
      out_removed_r   <= res_removed;
      out_pending_r   <= res_pending;
      out_served_r    <= res_served;
      out_last_r      <= res_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.fired_handler = out_handler_r;
  assign out_ch.fired_payload = out_payload_r;
  assign out_ch.fire_time     = out_fire_time_r;
  assign out_ch.remaining     = out_remaining_r;
  assign out_ch.removed_count = out_removed_r;
  assign out_ch.pending_count = out_pending_r;
  assign out_ch.served_count  = out_served_r;
  assign out_ch.last          = out_last_r;

endmodule

`default_nettype wire
